// File: rtl/per_id_delta_top_k_tracker_core_assert.svh
// Assertion macros shared by the tracker modules.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef PER_ID_DELTA_TOP_K_TRACKER_CORE_ASSERT_SVH
`define PER_ID_DELTA_TOP_K_TRACKER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define PDTK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PDTK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PDTK_ASSERT(label, prop, msg)
`define PDTK_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: rtl/pdtk_pkg.sv
package pdtk_pkg;

    localparam int ID_SLOTS    = 32768;
    localparam int TOP_COUNT   = 5;
    localparam int ID_W        = 15;
    localparam int TIME_W      = 32;
    localparam int DELTA_W     = 31;
    localparam int RANK_W      = 3;
    localparam int ID_AW       = $clog2(ID_SLOTS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Classified item handed from the front end to the list logic
    typedef struct packed {
        logic               compete;
        logic [ID_W-1:0]    id;
        logic [DELTA_W-1:0] delta;
        logic               last;
    } t_cls;

endpackage

// File: rtl/pdtk_front.sv
module pdtk_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [pdtk_pkg::ID_W-1:0]   i_proc_id,
    input  logic [pdtk_pkg::TIME_W-1:0] i_total_time,
    input  logic                       i_period_end,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output pdtk_pkg::t_cls             o_q_data
);

    logic [pdtk_pkg::TIME_W-1:0] r_mem [pdtk_pkg::ID_SLOTS];

    logic                         r_clr_busy;
    logic [pdtk_pkg::ID_AW-1:0]   r_clr_addr;

    logic                         r_s1_valid;
    logic [pdtk_pkg::ID_W-1:0]    r_s1_id;
    logic [pdtk_pkg::TIME_W-1:0]  r_s1_total;
    logic                         r_s1_last;
    logic [pdtk_pkg::TIME_W-1:0]  r_rd_data;

    logic                         r_fwd_valid;
    logic [pdtk_pkg::ID_W-1:0]    r_fwd_id;
    logic [pdtk_pkg::TIME_W-1:0]  r_fwd_data;

    logic                         in_accept;
    logic                         s1_push;
    logic                         s1_in_range;
    logic [pdtk_pkg::TIME_W-1:0]  prev_total;
    logic [pdtk_pkg::TIME_W-1:0]  diff;
    logic                         mem_we;
    logic [pdtk_pkg::ID_AW-1:0]   mem_waddr;
    logic [pdtk_pkg::TIME_W-1:0]  mem_wdata;

    assign s1_push   = r_s1_valid && !i_q_full;
    assign o_stall   = r_clr_busy || (r_s1_valid && i_q_full);
    assign in_accept = i_valid && !o_stall;

    assign s1_in_range = 32'(r_s1_id) < 32'(pdtk_pkg::ID_SLOTS);

    // The read was issued while the previous item wrote; take its value on an id match
    assign prev_total = (r_fwd_valid && r_fwd_id == r_s1_id) ? r_fwd_data : r_rd_data;
    assign diff       = r_s1_total - prev_total;

    always_comb begin
        o_q_push         = s1_push;
        o_q_data.compete = s1_in_range && (r_s1_id != '0) && (diff != '0)
                           && !diff[pdtk_pkg::TIME_W-1];
        o_q_data.id      = r_s1_id;
        o_q_data.delta   = diff[pdtk_pkg::DELTA_W-1:0];
        o_q_data.last    = r_s1_last;
    end

    assign mem_we    = r_clr_busy || (s1_push && s1_in_range);
    assign mem_waddr = r_clr_busy ? r_clr_addr : pdtk_pkg::ID_AW'(r_s1_id);
    assign mem_wdata = r_clr_busy ? '0 : r_s1_total;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept) begin
            r_rd_data <= r_mem[pdtk_pkg::ID_AW'(i_proc_id)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_id    <= i_proc_id;
            r_s1_total <= i_total_time;
            r_s1_last  <= i_period_end;
        end
        if (s1_push && s1_in_range) begin
            r_fwd_id   <= r_s1_id;
            r_fwd_data <= r_s1_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == pdtk_pkg::ID_AW'(pdtk_pkg::ID_SLOTS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_s1_valid <= in_accept || (r_s1_valid && !s1_push);
            if (s1_push && s1_in_range) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

`include "per_id_delta_top_k_tracker_core_assert.svh"

    `PDTK_ASSERT(a_clr_blocks_input, r_clr_busy |-> o_stall, "input taken during table clear")
    `PDTK_ASSERT_NEXT(a_fwd_tracks_write, s1_push && s1_in_range, r_fwd_valid && r_fwd_id == $past(r_s1_id), "forward register missed a write")
    `PDTK_ASSERT_NEXT(a_s1_holds, r_s1_valid && i_q_full, r_s1_valid && $stable(r_s1_id) && $stable(r_s1_total), "stage one changed while blocked")

endmodule

// File: rtl/pdtk_queue.sv
module pdtk_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pdtk_pkg::t_cls i_data,
    output logic           o_full,
    output logic           o_valid,
    output pdtk_pkg::t_cls o_data,
    input  logic           i_pop
);

    pdtk_pkg::t_cls              r_mem [pdtk_pkg::QUEUE_DEPTH];
    logic [pdtk_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [pdtk_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [pdtk_pkg::QPTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == (pdtk_pkg::QPTR_W + 1)'(pdtk_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == pdtk_pkg::QPTR_W'(pdtk_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == pdtk_pkg::QPTR_W'(pdtk_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/pdtk_back.sv
module pdtk_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  pdtk_pkg::t_cls              i_q_data,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [pdtk_pkg::RANK_W-1:0]  o_rank,
    output logic [pdtk_pkg::ID_W-1:0]    o_top_id,
    output logic [pdtk_pkg::DELTA_W-1:0] o_top_delta,
    output logic                        o_last_rank
);

    logic [pdtk_pkg::ID_W-1:0]    r_ids    [pdtk_pkg::TOP_COUNT];
    logic [pdtk_pkg::DELTA_W-1:0] r_dl     [pdtk_pkg::TOP_COUNT];
    logic [pdtk_pkg::ID_W-1:0]    n_ids    [pdtk_pkg::TOP_COUNT];
    logic [pdtk_pkg::DELTA_W-1:0] n_dl     [pdtk_pkg::TOP_COUNT];
    logic [pdtk_pkg::ID_W-1:0]    r_em_ids [pdtk_pkg::TOP_COUNT];
    logic [pdtk_pkg::DELTA_W-1:0] r_em_dl  [pdtk_pkg::TOP_COUNT];
    logic                         r_em_busy;
    logic [pdtk_pkg::RANK_W-1:0]  r_em_idx;

    logic [pdtk_pkg::TOP_COUNT-1:0] ge;
    logic                           out_xfer;
    logic                           em_last;
    logic                           em_free;
    logic                           load;

    assign out_xfer = r_em_busy && !i_stall;
    assign em_last  = r_em_idx == pdtk_pkg::RANK_W'(pdtk_pkg::TOP_COUNT - 1);
    assign em_free  = !r_em_busy || (out_xfer && em_last);
    // A period end waits until the emitter can take a fresh snapshot
    assign o_q_pop  = i_q_valid && (!i_q_data.last || em_free);
    assign load     = o_q_pop && i_q_data.last;

    assign o_valid     = r_em_busy;
    assign o_rank      = r_em_idx;
    assign o_top_id    = r_em_ids[0];
    assign o_top_delta = r_em_dl[0];
    assign o_last_rank = em_last;

    // The list stays sorted, so ge is a run of ones from the top; ties stay above
    always_comb begin
        for (int i = 0; i < pdtk_pkg::TOP_COUNT; i++) begin
            ge[i] = r_dl[i] >= i_q_data.delta;
        end
        if (i_q_data.compete && !ge[0]) begin
            n_ids[0] = i_q_data.id;
            n_dl[0]  = i_q_data.delta;
        end else begin
            n_ids[0] = r_ids[0];
            n_dl[0]  = r_dl[0];
        end
        for (int i = 1; i < pdtk_pkg::TOP_COUNT; i++) begin
            if (!i_q_data.compete || ge[i]) begin
                n_ids[i] = r_ids[i];
                n_dl[i]  = r_dl[i];
            end else if (ge[i-1]) begin
                n_ids[i] = i_q_data.id;
                n_dl[i]  = i_q_data.delta;
            end else begin
                n_ids[i] = r_ids[i-1];
                n_dl[i]  = r_dl[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_em_ids <= n_ids;
            r_em_dl  <= n_dl;
        end else if (out_xfer) begin
            for (int i = 0; i < pdtk_pkg::TOP_COUNT - 1; i++) begin
                r_em_ids[i] <= r_em_ids[i+1];
                r_em_dl[i]  <= r_em_dl[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pdtk_pkg::TOP_COUNT; i++) begin
                r_ids[i] <= '0;
                r_dl[i]  <= '0;
            end
            r_em_busy <= 1'b0;
            r_em_idx  <= '0;
        end else begin
            if (o_q_pop) begin
                if (i_q_data.last) begin
                    for (int i = 0; i < pdtk_pkg::TOP_COUNT; i++) begin
                        r_ids[i] <= '0;
                        r_dl[i]  <= '0;
                    end
                end else begin
                    r_ids <= n_ids;
                    r_dl  <= n_dl;
                end
            end
            if (load) begin
                r_em_busy <= 1'b1;
                r_em_idx  <= '0;
            end else if (out_xfer) begin
                r_em_idx <= r_em_idx + 1'b1;
                if (em_last) begin
                    r_em_busy <= 1'b0;
                end
            end
        end
    end

`include "per_id_delta_top_k_tracker_core_assert.svh"

    for (genvar g = 0; g < pdtk_pkg::TOP_COUNT - 1; g++) begin : g_sorted
        `PDTK_ASSERT(a_list_sorted, r_dl[g] >= r_dl[g+1], "top list out of order")
    end
    `PDTK_ASSERT_NEXT(a_snapshot_start, load, r_em_busy && r_em_idx == '0 && r_dl[0] == '0, "period end did not start a fresh run")
    `PDTK_ASSERT_NEXT(a_emit_holds, r_em_busy && i_stall, r_em_busy && $stable(r_em_idx) && $stable(r_em_dl[0]), "result moved while stalled")
    `PDTK_ASSERT(a_empty_slot, (r_dl[0] == '0) == (r_ids[0] == '0), "top slot id and delta disagree")

endmodule

// File: rtl/per_id_delta_top_k_tracker_core.sv
// Channel   Handshake                Payload
// input     i_valid / o_stall        i_proc_id, i_total_time, i_period_end
// output    o_valid / i_stall        o_rank, o_top_id, o_top_delta, o_last_rank
//
// One item per cycle enters while o_stall is low; the front end reads the per-id table,
// forwards the last write, classifies the registered item and queues it for the list.
// A period end yields five results from a snapshot; the list keeps
// taking items meanwhile, and a further period end waits for the last transfer.
// After reset the table is zeroed one entry a cycle, all 32768 entries, with o_stall high.
// o_stall is also high while the four-entry queue is full and stage one holds an item.
module per_id_delta_top_k_tracker_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [pdtk_pkg::ID_W-1:0]    i_proc_id,
    input  logic [pdtk_pkg::TIME_W-1:0]  i_total_time,
    input  logic                        i_period_end,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [pdtk_pkg::RANK_W-1:0]  o_rank,
    output logic [pdtk_pkg::ID_W-1:0]    o_top_id,
    output logic [pdtk_pkg::DELTA_W-1:0] o_top_delta,
    output logic                        o_last_rank
);

    logic           q_full;
    logic           q_push;
    logic           q_valid;
    logic           q_pop;
    pdtk_pkg::t_cls q_wdata;
    pdtk_pkg::t_cls q_rdata;

    pdtk_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_proc_id    (i_proc_id),
        .i_total_time (i_total_time),
        .i_period_end (i_period_end),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_wdata)
    );

    pdtk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata),
        .i_pop   (q_pop)
    );

    pdtk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rank      (o_rank),
        .o_top_id    (o_top_id),
        .o_top_delta (o_top_delta),
        .o_last_rank (o_last_rank)
    );

endmodule
